>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define LLQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define LLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/llq_pkg.sv
`timescale 1ns / 1ps

package llq_pkg;

    localparam int NODE_COUNT_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DATA_WIDTH      = 32;
    localparam int STATUS_WIDTH    = 2;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic reject;
        logic exec;
        logic link;
    } ctrl_cmd_t;

    typedef struct packed {
        logic enq;
        logic free_null;
        logic head_null;
        logic tail_node;
    } dp_status_t;

endpackage

>>> src/llq_ram.sv
`timescale 1ns / 1ps

module llq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/llq_ctrl.sv
`timescale 1ns / 1ps

module llq_ctrl import llq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       reject;

    assign busy = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign done = (state_reg == S_DONE);

    assign reject = dp_status.enq ? dp_status.free_null : dp_status.head_null;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.capture = start && !busy;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (reject)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (dp_status.enq && dp_status.tail_node)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = start ? S_READ : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/llq_dp.sv
`timescale 1ns / 1ps

module llq_dp import llq_pkg::*; #(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_cmd_t                     cmd,
    input  logic                          action,
    input  logic signed [DATA_WIDTH-1:0]  data_in,
    output dp_status_t                    dp_status,
    output logic [STATUS_WIDTH-1:0]       status,
    output logic signed [DATA_WIDTH-1:0]  data_out
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int PW = $clog2(NODE_COUNT + 1);
    localparam logic [PW-1:0] NULL_PTR = PW'(NODE_COUNT);

    logic                    action_reg;
    logic [DATA_WIDTH-1:0]   data_reg;
    logic [PW-1:0]           free_head_reg, free_head_next;
    logic [PW-1:0]           head_reg, head_next;
    logic [PW-1:0]           tail_reg, tail_next;
    logic [PW-1:0]           fill_reg, fill_next;
    logic [PW-1:0]           node_reg, node_next;
    logic [STATUS_WIDTH-1:0] status_reg, status_next;
    logic [DATA_WIDTH-1:0]   data_out_reg, data_out_next;

    logic                    enq;
    logic [PW-1:0]           rd_ptr;
    logic [PW-1:0]           link_rd;
    logic [PW-1:0]           link_eff;
    logic [PW-1:0]           new_head;
    logic [VALUE_WIDTH-1:0]  value_rd;
    logic [VALUE_WIDTH-1:0]  wr_value;
    logic [DATA_WIDTH-1:0]   rd_widened;

    logic                    link_we;
    logic [AW-1:0]           link_waddr;
    logic [PW-1:0]           link_wdata;
    logic                    value_we;

    assign enq    = (action_reg == ACT_ENQ);
    assign rd_ptr = enq ? free_head_reg : head_reg;

    assign dp_status.enq       = enq;
    assign dp_status.free_null = !(free_head_reg < NULL_PTR);
    assign dp_status.head_null = !(head_reg < NULL_PTR);
    assign dp_status.tail_node = (tail_reg < NULL_PTR);

    // nodes at or past the fill count still hold their reset link
    assign link_eff = (rd_ptr >= fill_reg) ? rd_ptr + PW'(1) : link_rd;
    assign new_head = (link_eff < NULL_PTR) ? link_eff : NULL_PTR;

    generate
        if (VALUE_WIDTH <= DATA_WIDTH)
        begin : g_narrow
            assign wr_value   = data_reg[VALUE_WIDTH-1:0];
            assign rd_widened = DATA_WIDTH'($signed(value_rd));
        end
        else
        begin : g_wide
            assign wr_value   = VALUE_WIDTH'(data_reg);
            assign rd_widened = value_rd[DATA_WIDTH-1:0];
        end
    endgenerate

    assign value_we = cmd.exec && enq;

    always_comb
    begin
        link_we    = cmd.exec || cmd.link;
        link_waddr = rd_ptr[AW-1:0];
        link_wdata = enq ? NULL_PTR : free_head_reg;
        if (cmd.link)
        begin
            link_waddr = tail_reg[AW-1:0];
            link_wdata = node_reg;
        end
    end

    llq_ram #(
        .WIDTH (PW),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (link_rd)
    );

    llq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NODE_COUNT)
    ) u_value_ram (
        .clk   (clk),
        .we    (value_we),
        .waddr (free_head_reg[AW-1:0]),
        .wdata (wr_value),
        .raddr (head_reg[AW-1:0]),
        .rdata (value_rd)
    );

    always_comb
    begin
        free_head_next = free_head_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        node_next      = node_reg;
        status_next    = status_reg;
        data_out_next  = data_out_reg;
        if (cmd.reject)
        begin
            status_next   = enq ? ST_FULL : ST_EMPTY;
            data_out_next = enq ? '0 : '1;
        end
        if (cmd.exec)
        begin
            status_next = ST_OK;
            if (enq)
            begin
                data_out_next  = '0;
                node_next      = free_head_reg;
                free_head_next = link_eff;
                if (free_head_reg >= fill_reg)
                begin
                    fill_next = fill_reg + PW'(1);
                end
                if (!(head_reg < NULL_PTR))
                begin
                    head_next = free_head_reg;
                end
                if (!(tail_reg < NULL_PTR))
                begin
                    tail_next = free_head_reg;
                end
            end
            else
            begin
                data_out_next  = rd_widened;
                free_head_next = head_reg;
                head_next      = new_head;
                if (new_head == NULL_PTR)
                begin
                    tail_next = NULL_PTR;
                end
            end
        end
        if (cmd.link)
        begin
            tail_next = node_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            head_reg      <= NULL_PTR;
            tail_reg      <= NULL_PTR;
            fill_reg      <= '0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            data_reg   <= data_in;
        end
        node_reg     <= node_next;
        status_reg   <= status_next;
        data_out_reg <= data_out_next;
    end

    assign status   = status_reg;
    assign data_out = data_out_reg;

endmodule

>>> src/linked_list_queue_free_list_top.sv
`timescale 1ns / 1ps
// channel   ports                            transfer when
// command   start, action, data_in, busy     start high and busy low at a clock edge
// result    done, status, data_out           done high, one cycle, no back-pressure
//
// an enqueue goes through read, exec and done after acceptance, with a link
// state before done when the queue already holds a node (a second write to
// the link store joins the old tail); a dequeue goes through read, exec and
// done; a full or empty rejection goes from read straight to done; the single
// write port of the link store and its registered read set these steps; a
// new command is taken in the cycle done is shown; rst_n clears the pointers;
// no clearing pass is needed, so busy is low straight after reset

module linked_list_queue_free_list_top import llq_pkg::*; #(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         action,
    input  logic signed [DATA_WIDTH-1:0] data_in,
    output logic                         busy,
    output logic                         done,
    output logic [STATUS_WIDTH-1:0]      status,
    output logic signed [DATA_WIDTH-1:0] data_out
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    llq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    llq_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (action),
        .data_in   (data_in),
        .dp_status (dp_status),
        .status    (status),
        .data_out  (data_out)
    );

endmodule

>>> src/llq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llq_checker import llq_pkg::*; (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [STATUS_WIDTH-1:0]      status,
    input logic signed [DATA_WIDTH-1:0] data_out
);

    `LLQ_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, start && !busy, busy)
    `LLQ_ASSERT_NEXT(a_done_single_cycle, clk, rst_n, done, !done)
    `LLQ_ASSERT_IMPLY(a_status_code, clk, rst_n, done, status <= ST_EMPTY)
    `LLQ_ASSERT_IMPLY(a_empty_value, clk, rst_n, done && (status == ST_EMPTY), data_out == -32'sd1)
    `LLQ_ASSERT_IMPLY(a_full_value, clk, rst_n, done && (status == ST_FULL), data_out == 32'sd0)

endmodule

bind linked_list_queue_free_list_top llq_checker u_llq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .data_out (data_out)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import llq_pkg::*;

    localparam int NODES     = NODE_COUNT_DEF;
    localparam int VW        = VALUE_WIDTH_DEF;
    localparam int LINK_NULL = NODES;
    localparam logic [63:0] VALUE_MASK = (VW >= 64) ? {64{1'b1}} : ((64'd1 << VW) - 64'd1);
    localparam int RANDOM_ITEMS = 1150;
    localparam int CALM_TAIL    = 150;

    typedef struct {
        logic [STATUS_WIDTH-1:0]      status;
        logic signed [DATA_WIDTH-1:0] data_out;
    } queue_result_t;

    class list_queue_checker;
        logic [63:0]   node_value [NODES];
        int            node_link [NODES];
        int            free_head;
        int            queue_head;
        int            queue_tail;
        queue_result_t expected_results [$];
        int            fail_count;

        function new();
            for (int i = 0; i < NODES; i++)
            begin
                node_value[i] = '0;
                node_link[i]  = i + 1;
            end
            free_head  = 0;
            queue_head = LINK_NULL;
            queue_tail = LINK_NULL;
            fail_count = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // accepted command: advance the list state and queue its result
        function void note_command(logic act, logic signed [DATA_WIDTH-1:0] value);
            queue_result_t r;
            int            n;
            logic [63:0]   v;
            r.status   = ST_OK;
            r.data_out = '0;
            if (act == ACT_ENQ)
            begin
                n = free_head;
                if (n >= NODES)
                    r.status = ST_FULL;
                else
                begin
                    free_head     = node_link[n];
                    node_value[n] = {{(64 - DATA_WIDTH){1'b0}}, value} & VALUE_MASK;
                    node_link[n]  = LINK_NULL;
                    if (queue_tail < NODES)
                        node_link[queue_tail] = n;
                    if (queue_head >= NODES)
                        queue_head = n;
                    queue_tail = n;
                end
            end
            else
            begin
                n = queue_head;
                if (n >= NODES)
                begin
                    r.status   = ST_EMPTY;
                    r.data_out = -1;
                end
                else
                begin
                    v = node_value[n] & VALUE_MASK;
                    if (VW < 64 && v[VW-1])
                        v = v | ~VALUE_MASK;
                    r.data_out = v[DATA_WIDTH-1:0];
                    queue_head = node_link[n];
                    if (queue_head >= NODES)
                    begin
                        queue_head = LINK_NULL;
                        queue_tail = LINK_NULL;
                    end
                    node_link[n] = free_head;
                    free_head    = n;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_WIDTH-1:0] st,
                                   logic signed [DATA_WIDTH-1:0] dout);
            queue_result_t r;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d data_out %0d", st, dout);
                return;
            end
            r = expected_results.pop_front();
            if (st !== r.status || dout !== r.data_out)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: status exp %0d got %0d, data_out exp %0d got %0d",
                             r.status, st, r.data_out, dout);
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         action;
    logic signed [DATA_WIDTH-1:0] data_in;
    logic                         busy;
    logic                         done;
    logic [STATUS_WIDTH-1:0]      status;
    logic signed [DATA_WIDTH-1:0] data_out;

    list_queue_checker chk;

    linked_list_queue_free_list_top #(
        .NODE_COUNT  (NODES),
        .VALUE_WIDTH (VW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (action),
        .data_in  (data_in),
        .busy     (busy),
        .done     (done),
        .status   (status),
        .data_out (data_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sample both channels at the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
                chk.check_result(status, data_out);
            if (start === 1'b1 && busy === 1'b0)
                chk.note_command(action, data_in);
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // one command transfer, then an optional idle burst
    task automatic send_command(input logic act, input logic signed [DATA_WIDTH-1:0] value,
                                input int idle_pct);
        int gap;
        start   <= 1'b1;
        action  <= act;
        data_in <= value;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 3);
            start   <= 1'b0;
            action  <= $urandom;
            data_in <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int enq_pct;
        int idle_pct;
        int wait_cycles;
        chk     = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        action  = ACT_ENQ;
        data_in = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty, fill with extremes, full, drain, empty again
        send_command(ACT_DEQ, 32'sh12345678, 25);
        send_command(ACT_ENQ, 32'sh00000000, 25);
        send_command(ACT_ENQ, -1, 25);
        send_command(ACT_ENQ, 32'sh7fffffff, 25);
        send_command(ACT_ENQ, 32'sh80000000, 25);
        send_command(ACT_ENQ, 32'sh55555555, 25);
        send_command(ACT_ENQ, 32'shaaaaaaaa, 25);
        send_command(ACT_ENQ, 32'sh00000001, 25);
        send_command(ACT_ENQ, 32'shfffffffe, 25);
        send_command(ACT_ENQ, 32'sh0badcafe, 25);
        for (int i = 0; i < NODES; i++)
            send_command(ACT_DEQ, random_value(), 25);
        send_command(ACT_DEQ, -1, 25);
        // tail must be cleared once the queue drains
        send_command(ACT_ENQ, 32'sh11111111, 0);
        send_command(ACT_DEQ, 0, 0);
        send_command(ACT_ENQ, 32'sh22222222, 0);
        send_command(ACT_ENQ, 32'sh33333333, 0);
        send_command(ACT_DEQ, 0, 0);
        send_command(ACT_DEQ, 0, 0);

        // random walk over fill levels, bias changed every 40 transfers
        enq_pct  = 50;
        idle_pct = 25;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 20;
                    1:       enq_pct = 50;
                    default: enq_pct = 80;
                endcase
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end
            if (i >= RANDOM_ITEMS - CALM_TAIL)
                idle_pct = 0;
            if ($urandom_range(0, 99) < enq_pct)
                send_command(ACT_ENQ, random_value(), idle_pct);
            else
                send_command(ACT_DEQ, random_value(), idle_pct);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (chk.pending() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);

        if (chk.pending() != 0)
            $display("results never seen: %0d", chk.pending());
        if (chk.fail_count == 0 && chk.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
